// File: rtl/max_heap_sift_down_defines.svh
// Assertion macros for the heap sift-down block.
`ifndef MAX_HEAP_SIFT_DOWN_DEFINES_SVH
`define MAX_HEAP_SIFT_DOWN_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MSD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MSD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: rtl/msd_pkg.sv
// Shared types, constants and codes of the heap sift-down block.
package msd_pkg;

   localparam int STORE_DEPTH = 1024;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int SIZE_W      = $clog2(STORE_DEPTH + 1);
   localparam int CHILD_W     = ADDR_W + 1;
   localparam int INDEX_W     = 10;
   localparam int HSIZE_W     = 11;
   localparam int DATA_W      = 32;

   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_SIFT  = 2'd2;

   typedef struct packed {
      logic [1:0]                operation;
      logic [INDEX_W-1:0]        index;
      logic [HSIZE_W-1:0]        heap_size;
      logic signed [DATA_W-1:0]  write_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  read_value;
      logic [INDEX_W-1:0]        settled_index;
   } rsp_type;

   typedef struct packed {
      logic                      we;
      logic                      re;
      logic [ADDR_W-1:0]         addr;
      logic [VALUE_WIDTH-1:0]    wdata;
   } mem_req_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_SNODE,
      S_LEFT,
      S_CMPL,
      S_CMPR,
      S_DECIDE,
      S_SWAP,
      S_DONE
   } state_type;

endpackage

// File: rtl/msd_store.sv
// Single-port element store with registered read data.
module msd_store (
   input  logic                              clock,
   input  msd_pkg::mem_req_type              mem_req,
   output logic [msd_pkg::VALUE_WIDTH-1:0]   rdata
);

   logic [msd_pkg::VALUE_WIDTH-1:0] mem [msd_pkg::STORE_DEPTH];
   logic [msd_pkg::VALUE_WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.addr] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rdata_ff <= mem[mem_req.addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/msd_cmp.sv
// Shared signed comparator for heap ordering.
module msd_cmp (
   input  logic [msd_pkg::VALUE_WIDTH-1:0] cand,
   input  logic [msd_pkg::VALUE_WIDTH-1:0] best,
   output logic                            greater
);

   // Strictly larger only, so the earlier candidate wins a tie.
   assign greater = $signed(cand) > $signed(best);

endmodule

// File: rtl/max_heap_sift_down.sv
// Top level of the heap sift-down block: sequencer, store and comparator.
//
// Each request item is a write, a read or a sift-down over a single-port store of
// msd_pkg::STORE_DEPTH signed entries, and yields one response item; the block works
// on one item at a time. A write goes straight to the done state, a read passes
// through the read state, and a sift-down reads the start node, then at each level
// reads the children that lie inside the heap, compares each with the best so far
// and, if one is larger, writes it to the node and the sifted value to that child
// and moves down a level. The single store port, one access a cycle, orders these
// steps, with one shared comparator judging each child. A new request item is taken
// while a finished response item still waits, but it cannot finish until that
// response item is taken. Entries that were never written read back undefined.
`include "max_heap_sift_down_defines.svh"

module max_heap_sift_down (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  msd_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output msd_pkg::rsp_type rsp_payload
);

   msd_pkg::state_type                state_ff, state_in;
   logic [msd_pkg::ADDR_W-1:0]        node_ff, node_in;
   logic [msd_pkg::ADDR_W-1:0]        best_ff, best_in;
   logic [msd_pkg::SIZE_W-1:0]        size_ff, size_in;
   logic [msd_pkg::VALUE_WIDTH-1:0]   node_val_ff, node_val_in;
   logic [msd_pkg::VALUE_WIDTH-1:0]   best_val_ff, best_val_in;
   logic [msd_pkg::INDEX_W-1:0]       settled_ff, settled_in;
   logic [msd_pkg::DATA_W-1:0]        res_rd_ff, res_rd_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   msd_pkg::rsp_type                  rsp_ff, rsp_in;

   msd_pkg::mem_req_type              mem_req;
   logic [msd_pkg::VALUE_WIDTH-1:0]   rdata;
   logic                              greater;
   logic [msd_pkg::CHILD_W-1:0]       left;
   logic [msd_pkg::CHILD_W-1:0]       right;
   logic [msd_pkg::CHILD_W-1:0]       size_ext;

   msd_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (rdata)
   );

   msd_cmp u_cmp (
      .cand    (rdata),
      .best    (best_val_ff),
      .greater (greater)
   );

   assign left     = {node_ff, 1'b1};
   assign right    = left + msd_pkg::CHILD_W'(1);
   assign size_ext = msd_pkg::CHILD_W'(size_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= msd_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      best_ff     <= best_in;
      size_ff     <= size_in;
      node_val_ff <= node_val_in;
      best_val_ff <= best_val_in;
      settled_ff  <= settled_in;
      res_rd_ff   <= res_rd_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      node_in      = node_ff;
      best_in      = best_ff;
      size_in      = size_ff;
      node_val_in  = node_val_ff;
      best_val_in  = best_val_ff;
      settled_in   = settled_ff;
      res_rd_in    = res_rd_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mem_req      = '0;

      // drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         msd_pkg::S_IDLE: begin
            if (req_valid) begin
               settled_in = req_payload.index;
               res_rd_in  = '0;
               node_in    = msd_pkg::ADDR_W'(req_payload.index);
               if (req_payload.heap_size > msd_pkg::STORE_DEPTH) begin
                  size_in = msd_pkg::SIZE_W'(msd_pkg::STORE_DEPTH);
               end else begin
                  size_in = msd_pkg::SIZE_W'(req_payload.heap_size);
               end
               state_in = msd_pkg::S_DONE;
               if (req_payload.index < msd_pkg::STORE_DEPTH) begin
                  mem_req.addr = msd_pkg::ADDR_W'(req_payload.index);
                  case (req_payload.operation)
                     msd_pkg::OP_WRITE: begin
                        mem_req.we    = 1'b1;
                        mem_req.wdata = msd_pkg::VALUE_WIDTH'(req_payload.write_value);
                     end
                     msd_pkg::OP_READ: begin
                        mem_req.re = 1'b1;
                        state_in   = msd_pkg::S_READ;
                     end
                     msd_pkg::OP_SIFT: begin
                        mem_req.re = 1'b1;
                        state_in   = msd_pkg::S_SNODE;
                     end
                     default: begin
                        state_in = msd_pkg::S_DONE;
                     end
                  endcase
               end
            end
         end
         msd_pkg::S_READ: begin
            res_rd_in = msd_pkg::DATA_W'(rdata);
            state_in  = msd_pkg::S_DONE;
         end
         msd_pkg::S_SNODE: begin
            node_val_in = rdata;
            state_in    = msd_pkg::S_LEFT;
         end
         msd_pkg::S_LEFT: begin
            best_val_in = node_val_ff;
            best_in     = node_ff;
            // right child lies past the left one, so no left child means a leaf
            if (left < size_ext) begin
               mem_req.re   = 1'b1;
               mem_req.addr = msd_pkg::ADDR_W'(left);
               state_in     = msd_pkg::S_CMPL;
            end else begin
               state_in = msd_pkg::S_DONE;
            end
         end
         msd_pkg::S_CMPL: begin
            if (greater) begin
               best_val_in = rdata;
               best_in     = msd_pkg::ADDR_W'(left);
            end
            if (right < size_ext) begin
               mem_req.re   = 1'b1;
               mem_req.addr = msd_pkg::ADDR_W'(right);
               state_in     = msd_pkg::S_CMPR;
            end else begin
               state_in = msd_pkg::S_DECIDE;
            end
         end
         msd_pkg::S_CMPR: begin
            if (greater) begin
               best_val_in = rdata;
               best_in     = msd_pkg::ADDR_W'(right);
            end
            state_in = msd_pkg::S_DECIDE;
         end
         msd_pkg::S_DECIDE: begin
            if (best_ff == node_ff) begin
               state_in = msd_pkg::S_DONE;
            end else begin
               mem_req.we    = 1'b1;
               mem_req.addr  = node_ff;
               mem_req.wdata = best_val_ff;
               state_in      = msd_pkg::S_SWAP;
            end
         end
         msd_pkg::S_SWAP: begin
            // the sifted value follows the node, so no reread is needed
            mem_req.we    = 1'b1;
            mem_req.addr  = best_ff;
            mem_req.wdata = node_val_ff;
            node_in       = best_ff;
            settled_in    = msd_pkg::INDEX_W'(best_ff);
            state_in      = msd_pkg::S_LEFT;
         end
         msd_pkg::S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in         = 1'b1;
               rsp_in.read_value    = res_rd_ff;
               rsp_in.settled_index = settled_ff;
               state_in             = msd_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = msd_pkg::S_IDLE;
         end
      endcase
   end

   assign req_ready   = (state_ff == msd_pkg::S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `MSD_ASSERT(a_accept_leaves_idle, (req_valid && req_ready) |=> (state_ff != msd_pkg::S_IDLE), "accepted item did not start work")
   `MSD_ASSERT(a_port_exclusive, !(mem_req.we && mem_req.re), "store read and write in one cycle")
   `MSD_ASSERT(a_swap_moves, (state_ff == msd_pkg::S_SWAP) |-> (best_ff != node_ff), "swap with itself")
   `MSD_ASSERT(a_done_to_rsp, (state_ff == msd_pkg::S_DONE && state_in == msd_pkg::S_IDLE) |=> rsp_valid_ff, "finished item not presented")
   `MSD_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid_ff, "response valid after reset")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the heap sift-down block: random ops against a shadow store.
module tb_top;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int ITEM_TARGET  = 950;
   localparam int DRAIN_CYCLES = 64;
   localparam int LONG_HOLD    = 400;

   logic             clock       = 1'b0;
   logic             reset       = 1'b1;
   logic             req_valid   = 1'b0;
   logic             req_ready;
   msd_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready   = 1'b0;
   msd_pkg::rsp_type rsp_payload;

   max_heap_sift_down uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // stimulus side: which entries hold a value, and the items still to send
   bit               entry_set [msd_pkg::STORE_DEPTH];
   msd_pkg::req_type pending [$];

   // prediction side: shadow of the element store and results still owed
   logic signed [msd_pkg::DATA_W-1:0] heap_shadow [msd_pkg::STORE_DEPTH];
   msd_pkg::rsp_type                  expected_rsp [$];

   int unsigned mismatches   = 0;
   int unsigned items_sent   = 0;
   int unsigned results_seen = 0;
   int unsigned sift_count   = 0;
   int unsigned sift_moved   = 0;
   int unsigned input_stalls = 0;
   int unsigned cycle_count  = 0;

   int send_gap       = 0;
   int send_mode_left = 0;
   bit send_calm      = 1'b0;
   int hold_left      = 0;
   int recv_mode_left = 0;
   bit recv_calm      = 1'b0;
   bit held_long      = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int pick_gap(bit calm);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic signed [msd_pkg::DATA_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2, 3, 4: return int'($urandom_range(0, 8)) - 4;   // narrow range to force ties
         default: return $urandom();
      endcase
   endfunction

   task automatic push_item(input logic [1:0] op, input int idx, input int size,
                            input logic signed [msd_pkg::DATA_W-1:0] value);
      msd_pkg::req_type item;
      item.operation   = op;
      item.index       = msd_pkg::INDEX_W'(idx);
      item.heap_size   = msd_pkg::HSIZE_W'(size);
      item.write_value = value;
      pending.insert(pending.size(), item);
      if (op == msd_pkg::OP_WRITE) entry_set[idx] = 1'b1;
   endtask

   task automatic put_value(input int idx);
      push_item(msd_pkg::OP_WRITE, idx, $urandom_range(0, 2047), pick_value());
   endtask

   // Walk the nodes a sift from root could touch; count or write the unset ones.
   task automatic walk_subtree(input int root, input int size, input bit fill,
                               output int missing);
      int nodes [$];
      int node;
      int lim;
      lim = (size > msd_pkg::STORE_DEPTH) ? msd_pkg::STORE_DEPTH : size;
      missing = 0;
      nodes.insert(nodes.size(), root);
      while (nodes.size() != 0) begin
         node = nodes.pop_front();
         if (!entry_set[node]) begin
            missing++;
            if (fill) put_value(node);
         end
         if (2 * node + 1 < lim) nodes.insert(nodes.size(), 2 * node + 1);
         if (2 * node + 2 < lim) nodes.insert(nodes.size(), 2 * node + 2);
      end
   endtask

   task automatic sift_at(input int idx, input int size);
      int missing;
      walk_subtree(idx, size, 1'b1, missing);
      push_item(msd_pkg::OP_SIFT, idx, size, pick_value());
   endtask

   task automatic read_at(input int idx);
      if (!entry_set[idx]) put_value(idx);
      push_item(msd_pkg::OP_READ, idx, $urandom_range(0, 2047), pick_value());
   endtask

   function automatic msd_pkg::rsp_type heap_step(msd_pkg::req_type item);
      msd_pkg::rsp_type                  res;
      int                                lim;
      int                                node;
      int                                left;
      int                                right;
      int                                best;
      bit                                at_rest;
      logic signed [msd_pkg::DATA_W-1:0] swap_val;
      res.read_value    = '0;
      res.settled_index = item.index;
      lim  = (int'(item.heap_size) > msd_pkg::STORE_DEPTH) ? msd_pkg::STORE_DEPTH
                                                           : int'(item.heap_size);
      node = int'(item.index);
      case (item.operation)
         msd_pkg::OP_WRITE: heap_shadow[node] = item.write_value;
         msd_pkg::OP_READ:  res.read_value = heap_shadow[node];
         msd_pkg::OP_SIFT: begin
            at_rest = 1'b0;
            while (!at_rest) begin
               left  = 2 * node + 1;
               right = 2 * node + 2;
               best  = node;
               // left wins a tie: right must be strictly larger
               if (left < lim && heap_shadow[left] > heap_shadow[best]) best = left;
               if (right < lim && heap_shadow[right] > heap_shadow[best]) best = right;
               if (best == node) begin
                  at_rest = 1'b1;
               end else begin
                  swap_val          = heap_shadow[node];
                  heap_shadow[node] = heap_shadow[best];
                  heap_shadow[best] = swap_val;
                  node              = best;
               end
            end
            res.settled_index = msd_pkg::INDEX_W'(node);
         end
         default: ;
      endcase
      return res;
   endfunction

   always @(posedge clock) begin : drive_requests
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_ready) input_stalls++;
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending.size() != 0) begin
               req_payload <= pending.pop_front();
               req_valid   <= 1'b1;
               if (send_mode_left == 0) begin
                  send_calm      = ($urandom_range(0, 3) == 0);
                  send_mode_left = $urandom_range(20, 120);
               end else begin
                  send_mode_left--;
               end
               send_gap = pick_gap(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : predict_results
      msd_pkg::rsp_type predicted;
      if (!reset && req_valid && req_ready) begin
         predicted = heap_step(req_payload);
         expected_rsp.insert(expected_rsp.size(), predicted);
         items_sent++;
         if (req_payload.operation == msd_pkg::OP_SIFT) begin
            sift_count++;
            if (predicted.settled_index != req_payload.index) sift_moved++;
         end
      end
   end

   always @(posedge clock) begin : take_results
      msd_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               mismatches++;
               $display("%0t: result with none expected, got value %0d index %0d",
                        $time, rsp_payload.read_value, rsp_payload.settled_index);
            end else begin
               want = expected_rsp.pop_front();
               results_seen++;
               if (rsp_payload.read_value !== want.read_value) begin
                  mismatches++;
                  $display("%0t: read_value expected %0d, got %0d",
                           $time, want.read_value, rsp_payload.read_value);
               end
               if (rsp_payload.settled_index !== want.settled_index) begin
                  mismatches++;
                  $display("%0t: settled_index expected %0d, got %0d",
                           $time, want.settled_index, rsp_payload.settled_index);
               end
            end
         end
         // one long hold-off so the block backs up and stalls its input
         if (!held_long && results_seen >= 250) begin
            hold_left = LONG_HOLD;
            held_long = 1'b1;
         end
         if (recv_mode_left == 0) begin
            recv_calm      = ($urandom_range(0, 3) == 0);
            recv_mode_left = $urandom_range(50, 400);
         end else begin
            recv_mode_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!recv_calm && $urandom_range(0, 99) < 25) hold_left = pick_gap(1'b0);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin : run_test
      int n;
      int k;
      int r;
      int j;
      int idx;
      int size;
      int missing;

      // extremes of value and index
      push_item(msd_pkg::OP_WRITE, 0, 0, 32'h7fff_ffff);
      push_item(msd_pkg::OP_WRITE, 1023, 2047, 32'h8000_0000);
      push_item(msd_pkg::OP_READ, 1023, 1024, 0);
      push_item(msd_pkg::OP_READ, 0, 0, 0);
      // equal children: the left one takes the node
      push_item(msd_pkg::OP_WRITE, 1, 3, -1);
      push_item(msd_pkg::OP_WRITE, 2, 3, -1);
      push_item(msd_pkg::OP_WRITE, 0, 3, -5);
      push_item(msd_pkg::OP_SIFT, 0, 3, 0);
      push_item(msd_pkg::OP_READ, 0, 3, 0);
      push_item(msd_pkg::OP_READ, 1, 3, 0);
      // start at or past the heap end, and oversized heaps
      push_item(msd_pkg::OP_SIFT, 0, 0, 0);
      push_item(msd_pkg::OP_SIFT, 1023, 2047, 0);
      push_item(msd_pkg::OP_SIFT, 1023, 1024, 0);
      push_item(msd_pkg::OP_WRITE, 3, 5, 10);
      push_item(msd_pkg::OP_WRITE, 4, 5, 20);
      // unused code leaves the store alone
      push_item(OP_UNUSED, 0, 5, 32'h5a5a_5a5a);
      push_item(msd_pkg::OP_READ, 0, 5, 0);
      // larger right child
      push_item(msd_pkg::OP_SIFT, 1, 5, 0);
      push_item(msd_pkg::OP_READ, 4, 5, 0);

      while (pending.size() < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            // fresh heap of random content, then sifts and reads inside it
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(64, 127) : $urandom_range(1, 40);
            for (j = 0; j < n; j++) put_value(j);
            if ($urandom_range(0, 2) == 0) begin
               for (j = n / 2 - 1; j >= 0; j--) sift_at(j, n);
               for (j = 0; j < 3; j++) read_at($urandom_range(0, n - 1));
            end else begin
               k = $urandom_range(1, 4);
               for (j = 0; j < k; j++) begin
                  r = $urandom_range(0, 9);
                  if (r < 3) sift_at(0, n);
                  else if (r < 6) sift_at($urandom_range(0, n - 1), n);
                  else if (r < 8) sift_at($urandom_range(0, 1023), $urandom_range(0, n));
                  else read_at($urandom_range(0, n - 1));
               end
            end
         end else if (r < 75) begin
            // any start and any size, kept where few unset entries lie below
            idx  = ($urandom_range(0, 1) == 0) ? $urandom_range(512, 1023)
                                               : $urandom_range(0, 1023);
            size = $urandom_range(0, 2047);
            walk_subtree(idx, size, 1'b0, missing);
            if (missing <= 40) sift_at(idx, size);
         end else if (r < 88) begin
            read_at($urandom_range(0, 1023));
         end else begin
            put_value($urandom_range(0, 1023));
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // sample at the falling edge, clear of the rising-edge updates
      while (pending.size() != 0 || req_valid) @(negedge clock);
      while (expected_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("ran %0d items: %0d sifts, %0d of them moving the value; %0d results checked",
               items_sent, sift_count, sift_moved, results_seen);
      $display("input backed up for %0d cycles, including one %0d-cycle result hold-off",
               input_stalls, LONG_HOLD);
      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// File: max_heap_sift_down.f
+incdir+rtl
rtl/msd_pkg.sv
rtl/msd_store.sv
rtl/msd_cmp.sv
rtl/max_heap_sift_down.sv
tb/tb_top.sv
